// ----- src/sad_block_best_match_macros.svh -----
// assertion helpers for the sad block best match design
`ifndef SAD_BLOCK_BEST_MATCH_MACROS_SVH
`define SAD_BLOCK_BEST_MATCH_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define SBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbm assertion failed");

// next-cycle implication, disabled while reset is low
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbm assertion failed");

`else

`define SBM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/sbm_pkg.sv -----
package sbm_pkg;

    localparam int unsigned BLOCK_HEIGHT = 32;
    localparam int unsigned BLOCK_WIDTH  = 16;
    localparam int unsigned CHANNELS     = 3;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LANES   = 16;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned SAD_W   = 19;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned VEC_W   = 12;
    localparam int unsigned PIX_MAX = 255;

    localparam int unsigned SAD_MAX_RAW = BLOCK_WIDTH * BLOCK_HEIGHT * PIX_MAX * CHANNELS;
    localparam int unsigned SAD_CAP     = (1 << SAD_W) - 2;

    // largest reachable block sad, capped so that one more still fits the field
    localparam logic [SAD_W-1:0] SAD_MAX =
        SAD_W'((SAD_MAX_RAW > SAD_CAP) ? SAD_CAP : SAD_MAX_RAW);
    localparam logic [SAD_W-1:0] SAD_INIT = SAD_MAX + SAD_W'(1);

endpackage

// ----- src/sbm_vec_sad.sv -----
module sbm_vec_sad (
    input  logic [sbm_pkg::HALF_W-1:0] i_source_low,
    input  logic [sbm_pkg::HALF_W-1:0] i_source_high,
    input  logic [sbm_pkg::HALF_W-1:0] i_candidate_low,
    input  logic [sbm_pkg::HALF_W-1:0] i_candidate_high,
    output logic [sbm_pkg::VEC_W-1:0]  o_vec_sad
);

    logic [2*sbm_pkg::HALF_W-1:0] w_src;
    logic [2*sbm_pkg::HALF_W-1:0] w_cand;
    logic [sbm_pkg::BYTE_W-1:0]   w_diff [16];
    logic [sbm_pkg::BYTE_W:0]     w_s1   [8];
    logic [sbm_pkg::BYTE_W+1:0]   w_s2   [4];
    logic [sbm_pkg::BYTE_W+2:0]   w_s3   [2];

    assign w_src  = {i_source_high, i_source_low};
    assign w_cand = {i_candidate_high, i_candidate_low};

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            if (w_src[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W] >
                w_cand[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W]) begin
                w_diff[k] = w_src[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W]
                          - w_cand[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W];
            end else begin
                w_diff[k] = w_cand[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W]
                          - w_src[k*sbm_pkg::BYTE_W +: sbm_pkg::BYTE_W];
            end
        end
    end

    // balanced adder tree over the 16 lane differences
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_s1[k] = {1'b0, w_diff[2*k]} + {1'b0, w_diff[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            w_s2[k] = {1'b0, w_s1[2*k]} + {1'b0, w_s1[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            w_s3[k] = {1'b0, w_s2[2*k]} + {1'b0, w_s2[2*k+1]};
        end
        o_vec_sad = {1'b0, w_s3[0]} + {1'b0, w_s3[1]};
    end

endmodule

// ----- src/sad_block_best_match.sv -----
// an input vector passes the input register and then the result register before its result shows on the outputs
// throughput: one input vector per cycle; an input register and a result
// register part the two sides, so input stalls only while a result waits
// and the vector in the input register ends a block
// reset (synchronous, active low) empties both registers, clears the running
// sad and sets the best sad to its maximum plus one with row and column zero
`include "sad_block_best_match_macros.svh"

module sad_block_best_match (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sbm_pkg::HALF_W-1:0]   i_source_low,
    input  logic [sbm_pkg::HALF_W-1:0]   i_source_high,
    input  logic [sbm_pkg::HALF_W-1:0]   i_candidate_low,
    input  logic [sbm_pkg::HALF_W-1:0]   i_candidate_high,
    input  logic                         i_block_end,
    input  logic                         i_search_end,
    input  logic [sbm_pkg::POS_W-1:0]    i_candidate_row,
    input  logic [sbm_pkg::POS_W-1:0]    i_candidate_col,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sbm_pkg::SAD_W-1:0]    o_block_sad,
    output logic                         o_new_best,
    output logic                         o_search_done,
    output logic [sbm_pkg::SAD_W-1:0]    o_best_sad,
    output logic [sbm_pkg::POS_W-1:0]    o_best_row,
    output logic [sbm_pkg::POS_W-1:0]    o_best_col
);

    // input register
    logic                       r_in_valid;
    logic [sbm_pkg::HALF_W-1:0] r_source_low;
    logic [sbm_pkg::HALF_W-1:0] r_source_high;
    logic [sbm_pkg::HALF_W-1:0] r_candidate_low;
    logic [sbm_pkg::HALF_W-1:0] r_candidate_high;
    logic                       r_block_end;
    logic                       r_search_end;
    logic [sbm_pkg::POS_W-1:0]  r_candidate_row;
    logic [sbm_pkg::POS_W-1:0]  r_candidate_col;

    // search state
    logic [sbm_pkg::SAD_W-1:0]  r_running_sad;
    logic [sbm_pkg::SAD_W-1:0]  r_best_sad;
    logic [sbm_pkg::POS_W-1:0]  r_best_row;
    logic [sbm_pkg::POS_W-1:0]  r_best_col;
    logic [sbm_pkg::SAD_W-1:0]  n_running_sad;
    logic [sbm_pkg::SAD_W-1:0]  n_best_sad;
    logic [sbm_pkg::POS_W-1:0]  n_best_row;
    logic [sbm_pkg::POS_W-1:0]  n_best_col;

    // result register
    logic                       r_out_valid;
    logic [sbm_pkg::SAD_W-1:0]  r_block_sad;
    logic                       r_new_best;
    logic                       r_search_done;
    logic [sbm_pkg::SAD_W-1:0]  r_out_best_sad;
    logic [sbm_pkg::POS_W-1:0]  r_out_best_row;
    logic [sbm_pkg::POS_W-1:0]  r_out_best_col;

    logic                       w_in_xfer;
    logic                       w_out_free;
    logic                       w_advance;
    logic                       w_emit;
    logic [sbm_pkg::VEC_W-1:0]  w_vec_sad;
    logic [sbm_pkg::SAD_W:0]    w_sum;
    logic [sbm_pkg::SAD_W-1:0]  w_sad;
    logic                       w_better;

    sbm_vec_sad u_vec_sad (
        .i_source_low     (r_source_low),
        .i_source_high    (r_source_high),
        .i_candidate_low  (r_candidate_low),
        .i_candidate_high (r_candidate_high),
        .o_vec_sad        (w_vec_sad)
    );

    // a vector without block end never needs the result register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!r_block_end || w_out_free);
    assign w_emit     = w_advance && r_block_end;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_sum = {1'b0, r_running_sad}
                 + {{(sbm_pkg::SAD_W + 1 - sbm_pkg::VEC_W){1'b0}}, w_vec_sad};
    assign w_sad = (w_sum > {1'b0, sbm_pkg::SAD_MAX}) ? sbm_pkg::SAD_MAX
                                                        : w_sum[sbm_pkg::SAD_W-1:0];
    assign w_better = w_sad < r_best_sad;

    always_comb begin
        n_running_sad = r_running_sad;
        n_best_sad    = r_best_sad;
        n_best_row    = r_best_row;
        n_best_col    = r_best_col;
        if (w_advance) begin
            if (!r_block_end) begin
                n_running_sad = w_sad;
            end else begin
                n_running_sad = '0;
                if (r_search_end) begin
                    n_best_sad = sbm_pkg::SAD_INIT;
                    n_best_row = '0;
                    n_best_col = '0;
                end else if (w_better) begin
                    n_best_sad = w_sad;
                    n_best_row = r_candidate_row;
                    n_best_col = r_candidate_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_running_sad <= '0;
            r_best_sad    <= sbm_pkg::SAD_INIT;
            r_best_row    <= '0;
            r_best_col    <= '0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_running_sad <= n_running_sad;
            r_best_sad    <= n_best_sad;
            r_best_row    <= n_best_row;
            r_best_col    <= n_best_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_source_low     <= i_source_low;
            r_source_high    <= i_source_high;
            r_candidate_low  <= i_candidate_low;
            r_candidate_high <= i_candidate_high;
            r_block_end      <= i_block_end;
            r_search_end     <= i_search_end;
            r_candidate_row  <= i_candidate_row;
            r_candidate_col  <= i_candidate_col;
        end
    end

    // result shows the best including this block, before any end-of-search clear
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_block_sad   <= w_sad;
            r_new_best    <= w_better;
            r_search_done <= r_search_end;
            if (w_better) begin
                r_out_best_sad <= w_sad;
                r_out_best_row <= r_candidate_row;
                r_out_best_col <= r_candidate_col;
            end else begin
                r_out_best_sad <= r_best_sad;
                r_out_best_row <= r_best_row;
                r_out_best_col <= r_best_col;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_sad   = r_block_sad;
    assign o_new_best    = r_new_best;
    assign o_search_done = r_search_done;
    assign o_best_sad    = r_out_best_sad;
    assign o_best_row    = r_out_best_row;
    assign o_best_col    = r_out_best_col;

    `SBM_ASSERT_SAME(a_new_best_sad, i_clk, i_rst_n, o_out_valid && o_new_best,
        o_best_sad == o_block_sad)
    `SBM_ASSERT_SAME(a_kept_best_le, i_clk, i_rst_n, o_out_valid && !o_new_best,
        o_best_sad <= o_block_sad)
    `SBM_ASSERT_NEXT(a_search_clear, i_clk, i_rst_n, w_emit && r_search_end,
        r_best_sad == sbm_pkg::SAD_INIT && r_running_sad == '0 && r_best_row == '0)
    `SBM_ASSERT_NEXT(a_running_cap, i_clk, i_rst_n, w_advance,
        r_running_sad <= sbm_pkg::SAD_MAX)

endmodule

// ----- verif/sad_block_best_match_tb.sv -----
`timescale 1ns / 1ps

module sad_block_best_match_tb;

    localparam logic [sbm_pkg::HALF_W-1:0] ALL0 = '0;
    localparam logic [sbm_pkg::HALF_W-1:0] ALL1 = '1;
    localparam logic [sbm_pkg::HALF_W-1:0] LANE_LSB = 64'h0101_0101_0101_0101;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct packed {
        logic [sbm_pkg::HALF_W-1:0] src_lo;
        logic [sbm_pkg::HALF_W-1:0] src_hi;
        logic [sbm_pkg::HALF_W-1:0] cand_lo;
        logic [sbm_pkg::HALF_W-1:0] cand_hi;
        logic                       blk_end;
        logic                       srch_end;
        logic [sbm_pkg::POS_W-1:0]  row;
        logic [sbm_pkg::POS_W-1:0]  col;
    } t_pix_vec;

    typedef struct packed {
        logic [sbm_pkg::SAD_W-1:0] block_sad;
        logic                      new_best;
        logic                      search_done;
        logic [sbm_pkg::SAD_W-1:0] best_sad;
        logic [sbm_pkg::POS_W-1:0] best_row;
        logic [sbm_pkg::POS_W-1:0] best_col;
    } t_match;

    typedef struct {
        t_pix_vec v;
        int       reps;
        bit       typed;
        t_match   want;
    } t_dir_row;

    typedef enum {RX_OPEN, RX_PATTERN, RX_RANDOM} t_rx_mode;
    typedef enum {FILL_RANDOM, FILL_SAME, FILL_NEAR, FILL_SWING} t_fill_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [sbm_pkg::HALF_W-1:0] i_source_low = '0;
    logic [sbm_pkg::HALF_W-1:0] i_source_high = '0;
    logic [sbm_pkg::HALF_W-1:0] i_candidate_low = '0;
    logic [sbm_pkg::HALF_W-1:0] i_candidate_high = '0;
    logic                       i_block_end = 1'b0;
    logic                       i_search_end = 1'b0;
    logic [sbm_pkg::POS_W-1:0]  i_candidate_row = '0;
    logic [sbm_pkg::POS_W-1:0]  i_candidate_col = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [sbm_pkg::SAD_W-1:0]  o_block_sad;
    logic                       o_new_best;
    logic                       o_search_done;
    logic [sbm_pkg::SAD_W-1:0]  o_best_sad;
    logic [sbm_pkg::POS_W-1:0]  o_best_row;
    logic [sbm_pkg::POS_W-1:0]  o_best_col;

    // predictor state
    logic [sbm_pkg::SAD_W-1:0] run_sad = '0;
    logic [sbm_pkg::SAD_W-1:0] best_sad_hold = sbm_pkg::SAD_INIT;
    logic [sbm_pkg::POS_W-1:0] best_row_hold = '0;
    logic [sbm_pkg::POS_W-1:0] best_col_hold = '0;

    t_match pending_matches[$];
    t_dir_row dir_tab[$];

    int err_count = 0;
    int vectors_sent = 0;
    int blocks_scored = 0;
    int best_updates = 0;
    int saturated_blocks = 0;
    int searches_closed = 0;
    int results_checked = 0;
    int burst_left = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [15:0] rx_pattern = 16'h1;

    sad_block_best_match i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_source_low     (i_source_low),
        .i_source_high    (i_source_high),
        .i_candidate_low  (i_candidate_low),
        .i_candidate_high (i_candidate_high),
        .i_block_end      (i_block_end),
        .i_search_end     (i_search_end),
        .i_candidate_row  (i_candidate_row),
        .i_candidate_col  (i_candidate_col),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_block_sad      (o_block_sad),
        .o_new_best       (o_new_best),
        .o_search_done    (o_search_done),
        .o_best_sad       (o_best_sad),
        .o_best_row       (o_best_row),
        .o_best_col       (o_best_col)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // sum of the 16 lane differences of one vector
    function automatic int unsigned vector_sad(input t_pix_vec v);
        int unsigned sum;
        int unsigned a;
        int unsigned b;
        sum = 0;
        for (int lane = 0; lane < 8; lane++) begin
            a = v.src_lo[8*lane +: 8];
            b = v.cand_lo[8*lane +: 8];
            sum += (a > b) ? a - b : b - a;
            a = v.src_hi[8*lane +: 8];
            b = v.cand_hi[8*lane +: 8];
            sum += (a > b) ? a - b : b - a;
        end
        return sum;
    endfunction

    task automatic score_vector(input t_pix_vec v, output bit emits, output t_match m);
        int unsigned total;
        logic [sbm_pkg::SAD_W-1:0] sad;
        bit better;
        total = int'(run_sad) + vector_sad(v);
        // running sum saturates, it never wraps
        sad = (total > sbm_pkg::SAD_MAX) ? sbm_pkg::SAD_MAX : total[sbm_pkg::SAD_W-1:0];
        emits = v.blk_end;
        m = '0;
        if (!v.blk_end) begin
            run_sad = sad;
        end else begin
            better = sad < best_sad_hold;
            if (better) begin
                best_sad_hold = sad;
                best_row_hold = v.row;
                best_col_hold = v.col;
                best_updates++;
            end
            m = '{sad, better, v.srch_end, best_sad_hold, best_row_hold, best_col_hold};
            blocks_scored++;
            if (sad == sbm_pkg::SAD_MAX) saturated_blocks++;
            run_sad = '0;
            if (v.srch_end) begin
                best_sad_hold = sbm_pkg::SAD_INIT;
                best_row_hold = '0;
                best_col_hold = '0;
                searches_closed++;
            end
        end
    endtask

    // called at a rising edge, returns at the rising edge of the transfer
    task automatic send_vector(input t_pix_vec v, input bit typed, input t_match want);
        int gap;
        bit took;
        bit emits;
        t_match m;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_source_low     <= v.src_lo;
        i_source_high    <= v.src_hi;
        i_candidate_low  <= v.cand_lo;
        i_candidate_high <= v.cand_hi;
        i_block_end      <= v.blk_end;
        i_search_end     <= v.srch_end;
        i_candidate_row  <= v.row;
        i_candidate_col  <= v.col;
        do begin
            // inputs only move at rising edges, so ready is settled here
            @(negedge i_clk);
            took = o_in_ready;
            if (took) begin
                score_vector(v, emits, m);
                vectors_sent++;
                if (emits) pending_matches.push_back(typed ? want : m);
            end
            @(posedge i_clk);
        end while (!took);
    endtask

    function automatic logic [sbm_pkg::HALF_W-1:0] swing_half();
        logic [sbm_pkg::HALF_W-1:0] h;
        for (int lane = 0; lane < 8; lane++)
            h[8*lane +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return h;
    endfunction

    function automatic t_pix_vec make_vector(input t_fill_mode fill);
        t_pix_vec v;
        v.src_lo = {$urandom, $urandom};
        v.src_hi = {$urandom, $urandom};
        case (fill)
            FILL_SAME: begin
                v.cand_lo = v.src_lo;
                v.cand_hi = v.src_hi;
            end
            FILL_NEAR: begin
                // lane differences of 0 or 1 make equal block sums likely
                v.cand_lo = v.src_lo ^ ({$urandom, $urandom} & LANE_LSB);
                v.cand_hi = v.src_hi ^ ({$urandom, $urandom} & LANE_LSB);
            end
            FILL_SWING: begin
                v.cand_lo = swing_half();
                v.cand_hi = swing_half();
                v.src_lo = ~v.cand_lo;
                v.src_hi = ~v.cand_hi;
            end
            default: begin
                v.cand_lo = {$urandom, $urandom};
                v.cand_hi = {$urandom, $urandom};
            end
        endcase
        v.blk_end = 1'b0;
        v.srch_end = 1'b0;
        v.row = $urandom_range(0, 4095);
        v.col = $urandom_range(0, 4095);
        return v;
    endfunction

    task automatic random_search();
        int n_cand;
        int len;
        int pick;
        t_fill_mode fill;
        t_pix_vec v;
        n_cand = $urandom_range(1, 6);
        for (int c = 0; c < n_cand; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) len = $urandom_range(1, 4);
            else if (pick < 97) len = $urandom_range(5, 32);
            else len = $urandom_range(95, 110);
            if (len > 90 && $urandom_range(0, 3) != 0) fill = FILL_SWING;
            else fill = t_fill_mode'($urandom_range(0, 3));
            for (int k = 0; k < len; k++) begin
                v = make_vector(fill);
                v.blk_end = (k == len - 1);
                // stray search end inside a block must be ignored
                v.srch_end = v.blk_end ? (c == n_cand - 1) : ($urandom_range(0, 9) == 0);
                send_vector(v, 1'b0, '0);
            end
        end
    endtask

    function automatic t_dir_row mk_row(input t_pix_vec v, input int reps, input bit typed,
                                        input t_match want);
        t_dir_row r;
        r.v = v;
        r.reps = reps;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // receiver: open stretches, a rotating stall pattern, or random stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(48, 160);
            rx_pattern = 16'($urandom) | 16'h1;
        end
        rx_left--;
        case (rx_mode)
            RX_PATTERN: begin
                i_out_ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
            default:   i_out_ready <= 1'b1;
        endcase
    end

    // outputs are settled at the falling edge; a transfer seen here completes
    // at the next rising edge
    always @(negedge i_clk) begin : result_check
        t_match want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_matches.size() == 0) begin
                $error("result with no expectation pending: block_sad %0d", o_block_sad);
                err_count++;
            end else begin
                want = pending_matches.pop_front();
                check_field("block_sad", want.block_sad, o_block_sad);
                check_field("new_best", want.new_best, o_new_best);
                check_field("search_done", want.search_done, o_search_done);
                check_field("best_sad", want.best_sad, o_best_sad);
                check_field("best_row", want.best_row, o_best_row);
                check_field("best_col", want.best_col, o_best_col);
                results_checked++;
            end
        end
    end

    initial begin
        int waited;
        t_dir_row r;

        // first block after reset: every lane at full difference
        dir_tab.push_back(mk_row('{ALL0, ALL0, ALL1, ALL1, 1'b1, 1'b0, 12'hFFF, 12'hFFF},
            1, 1'b1, '{19'd4080, 1'b1, 1'b0, 19'd4080, 12'hFFF, 12'hFFF}));
        // equal sum keeps the earlier candidate
        dir_tab.push_back(mk_row('{ALL1, ALL1, ALL0, ALL0, 1'b1, 1'b0, 12'h000, 12'h000},
            1, 1'b1, '{19'd4080, 1'b0, 1'b0, 19'd4080, 12'hFFF, 12'hFFF}));
        // exact match closes the search
        dir_tab.push_back(mk_row('{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
            64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 12'h123, 12'h456},
            1, 1'b1, '{19'd0, 1'b1, 1'b1, 19'd0, 12'h123, 12'h456}));
        // search end without block end: no result, sum carries on
        dir_tab.push_back(mk_row('{ALL0, ALL0, ALL1, ALL1, 1'b0, 1'b1, 12'hFFF, 12'hFFF},
            1, 1'b0, '0));
        dir_tab.push_back(mk_row('{64'h5A5A_5A5A_5A5A_5A5A, ALL1, 64'h5A5A_5A5A_5A5A_5A5A,
            ALL1, 1'b1, 1'b0, 12'h001, 12'h002},
            1, 1'b1, '{19'd4080, 1'b1, 1'b0, 19'd4080, 12'h001, 12'h002}));
        // overlong block saturates and loses to the held best
        dir_tab.push_back(mk_row('{ALL1, ALL0, ALL0, ALL1, 1'b0, 1'b0, 12'h000, 12'h000},
            100, 1'b0, '0));
        dir_tab.push_back(mk_row('{ALL1, ALL0, ALL0, ALL1, 1'b1, 1'b1, 12'h800, 12'h001},
            1, 1'b1, '{sbm_pkg::SAD_MAX, 1'b0, 1'b1, 19'd4080, 12'h001, 12'h002}));
        // saturated first block of a search still beats the cleared best
        dir_tab.push_back(mk_row('{ALL0, ALL1, ALL1, ALL0, 1'b0, 1'b0, 12'h000, 12'h000},
            99, 1'b0, '0));
        dir_tab.push_back(mk_row('{ALL0, ALL1, ALL1, ALL0, 1'b1, 1'b0, 12'hABC, 12'h555},
            1, 1'b1, '{sbm_pkg::SAD_MAX, 1'b1, 1'b0, sbm_pkg::SAD_MAX, 12'hABC, 12'h555}));
        dir_tab.push_back(mk_row('{64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F,
            64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080, 1'b0, 1'b0, 12'h000, 12'h000},
            1, 1'b0, '0));
        dir_tab.push_back(mk_row('{64'h0123_4567_89AB_CDEF, 64'h00FF_10EF_20DF_30CF,
            64'hFEDC_BA98_7654_3210, 64'hFF00_EF10_DF20_CF30, 1'b1, 1'b0, 12'h7FF, 12'h800},
            1, 1'b0, '0));
        dir_tab.push_back(mk_row('{64'hC3C3_0000_FFFF_3C3C, 64'h00FF_00FF_00FF_00FF,
            64'hC3C3_0000_FFFF_3C3C, 64'hFF00_FF00_FF00_FF00, 1'b1, 1'b1, 12'h000, 12'hFFF},
            1, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_tab.size(); i++) begin
            r = dir_tab[i];
            for (int k = 0; k < r.reps; k++) send_vector(r.v, r.typed, r.want);
        end

        waited = vectors_sent;
        while (vectors_sent - waited < RANDOM_ITEMS) random_search();
        i_in_valid <= 1'b0;

        for (int n = 0; n < DRAIN_LIMIT && pending_matches.size() != 0; n++)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (pending_matches.size() != 0) begin
            $error("%0d expected results never arrived", pending_matches.size());
            err_count += pending_matches.size();
        end

        $display("sent %0d vectors forming %0d blocks in %0d closed searches",
                 vectors_sent, blocks_scored, searches_closed);
        $display("%0d results checked, %0d new best, %0d blocks at the saturated sum",
                 results_checked, best_updates, saturated_blocks);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/sbm_pkg.sv
src/sbm_vec_sad.sv
src/sad_block_best_match.sv
verif/sad_block_best_match_tb.sv
